[src/list_header_recognizer_defines.svh]
// assertion helpers for the list header recognizer
`ifndef LIST_HEADER_RECOGNIZER_DEFINES_SVH
`define LIST_HEADER_RECOGNIZER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LHR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LHR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/lhr_pkg.sv]
package lhr_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_SHORT   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    PH_KEYWORD = 4'd0,
    PH_OPEN    = 4'd1,
    PH_LETTERS = 4'd2,
    PH_SPACE1  = 4'd3,
    PH_DIGITS  = 4'd4,
    PH_SPACE2  = 4'd5
  } phase_t;

  localparam int NumTypes = 3;
  localparam int TypeLen  = 6;

  localparam logic [7:0] KW_BYTES [4] = '{8'h4C, 8'h69, 8'h73, 8'h74};

  localparam logic [7:0] TYPE_NAMES [NumTypes][TypeLen] = '{
    '{8'h73, 8'h63, 8'h61, 8'h6C, 8'h61, 8'h72},
    '{8'h76, 8'h65, 8'h63, 8'h74, 8'h6F, 8'h72},
    '{8'h74, 8'h65, 8'h6E, 8'h73, 8'h6F, 8'h72}
  };

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_PAREN = 8'h28;

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

endpackage

[src/lhr_byte_if.sv]
interface lhr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

[src/lhr_status_if.sv]
interface lhr_status_if;
  import lhr_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;

  modport source (output valid, output status, input ready);
  modport sink (input valid, input status, output ready);
endinterface

[src/list_header_recognizer.sv]
`include "list_header_recognizer_defines.svh"

// Checks whether each buffer of a byte stream opens with List<scalar>, List<vector> or
// List<tensor>, then optional whitespace, optional digits and whitespace, then '('.
// One byte is taken per cycle unless a new status is due while the last one waits. A
// byte goes into an input register, is judged there against the recognizer state, and
// a status lands in the output register. One status is given per buffer (ok, invalid
// or short); bytes after the verdict are absorbed, and the byte flagged end_of_buffer
// puts the recognizer back to its start state. The output register and the input
// register stall together only while a status waits.
module list_header_recognizer (
  input  logic         clk,
  input  logic         rst,
  lhr_byte_if.sink     bytes,
  lhr_status_if.source result
);
  import lhr_pkg::*;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  // recognizer state
  phase_t     phase, phase_next;
  logic [2:0] match_index, match_index_next;
  logic [2:0] type_candidates, type_candidates_next;
  logic       keyword_mismatch, keyword_mismatch_next;
  logic       decided, decided_next;

  // output register
  logic    out_valid;
  status_t out_status;

  logic    emit;
  status_t st;
  logic    proc_fire;

  always_comb begin
    phase_next            = phase;
    match_index_next      = match_index;
    type_candidates_next  = type_candidates;
    keyword_mismatch_next = keyword_mismatch;
    decided_next          = decided;
    emit                  = 1'b0;
    st                    = ST_SHORT;

    if (!decided) begin
      case (phase)
        PH_KEYWORD: begin
          if (s1_byte != KW_BYTES[match_index[1:0]]) begin
            keyword_mismatch_next = 1'b1;
          end
          if (match_index[1:0] == 2'd3) begin
            if (keyword_mismatch_next) begin
              emit = 1'b1;
              st   = ST_INVALID;
            end else begin
              phase_next = PH_OPEN;
            end
            match_index_next = 3'd0;
          end else begin
            match_index_next = {1'b0, match_index[1:0] + 2'd1};
          end
        end
        PH_OPEN: begin
          if (s1_byte == CH_LT) begin
            phase_next           = PH_LETTERS;
            match_index_next     = 3'd0;
            type_candidates_next = 3'b111;
          end else begin
            emit = 1'b1;
            st   = ST_INVALID;
          end
        end
        PH_LETTERS: begin
          if (is_letter(s1_byte)) begin
            if (match_index < 3'(TypeLen)) begin
              for (int k = 0; k < NumTypes; k++) begin
                if (TYPE_NAMES[k][match_index] != s1_byte) begin
                  type_candidates_next[k] = 1'b0;
                end
              end
            end else begin
              type_candidates_next = 3'b000;
            end
            if (match_index != 3'd7) begin
              match_index_next = match_index + 3'd1;
            end
          end else if (s1_byte == CH_GT && match_index == 3'(TypeLen)
                       && type_candidates != 3'b000) begin
            phase_next = PH_SPACE1;
          end else begin
            emit = 1'b1;
            st   = ST_INVALID;
          end
        end
        PH_SPACE1, PH_DIGITS, PH_SPACE2: begin
          if (s1_byte == CH_PAREN) begin
            emit = 1'b1;
            st   = ST_OK;
          end else if (is_space(s1_byte)) begin
            if (phase == PH_DIGITS) begin
              phase_next = PH_SPACE2;
            end
          end else if (is_digit(s1_byte) && phase != PH_SPACE2) begin
            phase_next = PH_DIGITS;
          end else begin
            emit = 1'b1;
            st   = ST_INVALID;
          end
        end
        default: begin
          emit = 1'b1;
          st   = ST_INVALID;
        end
      endcase

      if (emit) begin
        decided_next = 1'b1;
      end else if (s1_last) begin
        emit = 1'b1;
        st   = ST_SHORT;
      end
    end

    // end of buffer: back to the start state
    if (s1_last) begin
      phase_next            = PH_KEYWORD;
      match_index_next      = 3'd0;
      type_candidates_next  = 3'b111;
      keyword_mismatch_next = 1'b0;
      decided_next          = 1'b0;
    end
  end

  // an item in the input register is retired unless its status has nowhere to go
  assign proc_fire   = s1_valid && (!emit || !out_valid || result.ready);
  assign bytes.ready = !s1_valid || proc_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (bytes.ready) begin
      s1_valid <= bytes.valid;
    end
    if (bytes.ready && bytes.valid) begin
      s1_byte <= bytes.data_byte;
      s1_last <= bytes.end_of_buffer;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_KEYWORD;
      match_index      <= 3'd0;
      type_candidates  <= 3'b111;
      keyword_mismatch <= 1'b0;
      decided          <= 1'b0;
    end else if (proc_fire) begin
      phase            <= phase_next;
      match_index      <= match_index_next;
      type_candidates  <= type_candidates_next;
      keyword_mismatch <= keyword_mismatch_next;
      decided          <= decided_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_fire && emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (proc_fire && emit) begin
      out_status <= st;
    end
  end

  assign result.valid  = out_valid;
  assign result.status = out_status;

  `LHR_ASSERT_NEXT(a_eob_resets, proc_fire && s1_last, phase == PH_KEYWORD && !decided && match_index == 3'd0, "state not cleared after end of buffer")
  `LHR_ASSERT_NOW(a_absorb_quiet, proc_fire && decided && !s1_last, !emit, "status given twice in one buffer")
  `LHR_ASSERT_NEXT(a_status_lands, proc_fire && emit, out_valid, "status lost on its way to the output register")
  `LHR_ASSERT_NOW(a_header_len, phase == PH_SPACE1 || phase == PH_DIGITS || phase == PH_SPACE2, match_index == 3'(TypeLen) && type_candidates != 3'b000, "header accepted with a bad type name")

endmodule
